// File: rtl/core/gtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_pkg: shared definitions for the gnomonic tangent plane projection
// Fixed-point formats, series divisors, status codes and register indexes.
// ----------------------------------------------------------------------------
package gtp_pkg;

   localparam int ANGLE_BITS_DEFAULT      = 32;
   localparam int COORD_FRAC_BITS_DEFAULT = 24;

   localparam int ANGLE_W = 32;   // binary angle, full turn is 2^32
   localparam int OUT_W   = 48;   // width of xi and eta
   localparam int FRAC_W  = 30;   // sine and cosine are Q30
   localparam int TRIG_W  = 32;   // signed sine and cosine words

   localparam logic [FRAC_W:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [FRAC_W:0] HALF_PI_Q30 = 31'd1686629713;
   localparam int              TINY_Q30    = 1074;

   // Horner steps of the two Taylor series; the unit runs the longer one.
   localparam int SIN_TERMS = 5;
   localparam int COS_TERMS = 6;
   localparam int SC_STEPS  = COS_TERMS;
   // Folding, scaling by pi/2, squaring, three stages per Horner step, final product and sign.
   localparam int SC_LAT    = 3 * SC_STEPS + 5;

   localparam logic [7:0] SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [7:0] COS_DIV [COS_TERMS] =
      '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

   // Reciprocals floor(2^30 / divisor); the estimate is low by at most one.
   localparam logic [FRAC_W-1:0] SIN_RECIP [SIN_TERMS] = '{
      30'((2 ** 30) / 110), 30'((2 ** 30) / 72), 30'((2 ** 30) / 42),
      30'((2 ** 30) / 20), 30'((2 ** 30) / 6)};
   localparam logic [FRAC_W-1:0] COS_RECIP [COS_TERMS] = '{
      30'((2 ** 30) / 132), 30'((2 ** 30) / 90), 30'((2 ** 30) / 56),
      30'((2 ** 30) / 30), 30'((2 ** 30) / 12), 30'((2 ** 30) / 2)};

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TANGENT_RA  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TANGENT_DEC = 1'd1;

   typedef enum logic [1:0] {
      STATUS_OK                = 2'd0,
      STATUS_TOO_FAR           = 2'd1,
      STATUS_ANTISTAR_ON_PLANE = 2'd2,
      STATUS_ANTISTAR_TOO_FAR  = 2'd3
   } status_type;

endpackage
`default_nettype wire

// File: rtl/core/gnomonic_tangent_plane_projection.sv
`default_nettype none
// Throughput: one request per cycle while req_ready is high; the trig units, the product
// stages and the one-quotient-bit-per-stage dividers are all fully pipelined.
// A stalled output parks one result in a skid register; req_ready drops only then.
// Reset (synchronous, active high) clears all valid bits and both tangent registers.
// ----------------------------------------------------------------------------
// gnomonic_tangent_plane_projection: star to tangent plane standard coordinates
// Three sine/cosine pipelines, product stages for the numerators and the
// denominator, clamping of the denominator and two restoring dividers.
// ----------------------------------------------------------------------------
module gnomonic_tangent_plane_projection
   import gtp_pkg::*;
#(
   parameter int ANGLE_BITS      = ANGLE_BITS_DEFAULT,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ANGLE_W-1:0]      req_star_ra,
   input  logic signed [ANGLE_W-1:0] req_star_dec,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_plane_xi,
   output logic signed [OUT_W-1:0] rsp_plane_eta,
   output logic [1:0]              rsp_projection_status,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [ANGLE_W-1:0]      csr_write_data
);

   localparam int TURN_RSH = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
   localparam int TURN_LSH = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
   localparam logic [63:0] ANGLE_MASK = (64'd1 << ANGLE_BITS) - 64'd1;

   localparam int PROD_W = 64;
   localparam int NUM_W  = 63;
   localparam int DEN_W  = 33;
   localparam int QB     = OUT_W - 1;
   localparam int EXT_N  = (COORD_FRAC_BITS > 30) ? COORD_FRAC_BITS - 30 : 0;
   localparam int EXT_D  = (COORD_FRAC_BITS < 30) ? 30 - COORD_FRAC_BITS : 0;
   localparam int VW     = DEN_W + EXT_D;
   localparam int DW_A   = NUM_W + EXT_N;
   localparam int DW_B   = VW + QB;
   localparam int DIV_W  = ((DW_A > DW_B) ? DW_A : DW_B) + 1;
   localparam logic signed [DEN_W:0] TINY_DEN = (DEN_W+1)'(TINY_Q30);
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {QB{1'b1}}};

   typedef struct packed {
      logic       negx;
      logic       nege;
      logic       satx;
      logic       sate;
      status_type status;
   } div_info_type;

   function automatic logic [ANGLE_W-1:0] to_turn(input logic [63:0] v);
      logic [63:0] m;
      m = v & ANGLE_MASK;
      return ANGLE_W'((m >> TURN_RSH) << TURN_LSH);
   endfunction

   // Configuration registers.
   logic [ANGLE_W-1:0] tangent_ra_ff, tangent_dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tangent_ra_ff  <= '0;
         tangent_dec_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TANGENT_RA:  tangent_ra_ff  <= csr_write_data;
            CSR_TANGENT_DEC: tangent_dec_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // Input stage: angles brought to a 32-bit turn.
   logic               v0_ff;
   logic [ANGLE_W-1:0] dec_a_ff, tdec_a_ff, diff_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dec_a_ff  <= to_turn(64'(req_star_dec));
         tdec_a_ff <= to_turn(64'($signed(tangent_dec_ff)));
         diff_a_ff <= to_turn(64'(req_star_ra)) - to_turn(64'(tangent_ra_ff));
      end
   end

   logic signed [TRIG_W-1:0] sd, cd, st, ct, sr, cr;

   gtp_sincos u_sc_star (.clock(clock), .en(en), .angle(dec_a_ff),
                         .sin_out(sd), .cos_out(cd));
   gtp_sincos u_sc_tangent (.clock(clock), .en(en), .angle(tdec_a_ff),
                            .sin_out(st), .cos_out(ct));
   gtp_sincos u_sc_diff (.clock(clock), .en(en), .angle(diff_a_ff),
                         .sin_out(sr), .cos_out(cr));

   // Product stages for the numerators and the denominator.
   logic signed [PROD_W-1:0] k1_sdst_in, k1_sdct_in, k1_cdct_in, k1_cdst_in, k1_xnum_in;
   logic signed [PROD_W-1:0] k1_sdst_ff, k1_sdct_ff, k1_cdct_ff, k1_cdst_ff, k1_xnum_ff;
   logic signed [TRIG_W-1:0] k1_cr_ff;

   assign k1_sdst_in = sd * st;
   assign k1_sdct_in = sd * ct;
   assign k1_cdct_in = cd * ct;
   assign k1_cdst_in = cd * st;
   assign k1_xnum_in = cd * sr;

   logic signed [PROD_W-1:0] k1_cdct_sh, k1_cdst_sh;
   logic signed [TRIG_W-1:0] k2_a_in, k2_b_in;
   logic signed [PROD_W-1:0] k2_m1_in, k2_m2_in;
   logic signed [PROD_W-1:0] k2_m1_ff, k2_m2_ff, k2_sdst_ff, k2_sdct_ff, k2_xnum_ff;

   assign k1_cdct_sh = k1_cdct_ff >>> 30;
   assign k1_cdst_sh = k1_cdst_ff >>> 30;
   assign k2_a_in    = TRIG_W'(k1_cdct_sh);
   assign k2_b_in    = TRIG_W'(k1_cdst_sh);
   assign k2_m1_in   = k2_a_in * k1_cr_ff;
   assign k2_m2_in   = k2_b_in * k1_cr_ff;

   logic signed [PROD_W-1:0] k3_sum_in, k3_sum_sh;
   logic signed [DEN_W:0]    k3_den_ff;
   logic signed [PROD_W-1:0] k3_enum_ff, k3_xnum_ff;

   assign k3_sum_in = k2_sdst_ff + k2_m1_ff;
   assign k3_sum_sh = k3_sum_in >>> 30;

   // Clamp the denominator away from zero and split off the signs.
   status_type            status_in;
   logic signed [DEN_W:0] den_fix_in, den_neg_in;
   logic signed [PROD_W-1:0] xnum_abs_in, enum_abs_in;

   always_comb begin
      if (k3_den_ff > TINY_DEN) begin
         status_in  = STATUS_OK;
         den_fix_in = k3_den_ff;
      end else if (!k3_den_ff[DEN_W]) begin
         status_in  = STATUS_TOO_FAR;
         den_fix_in = TINY_DEN;
      end else if (k3_den_ff > -TINY_DEN) begin
         status_in  = STATUS_ANTISTAR_ON_PLANE;
         den_fix_in = -TINY_DEN;
      end else begin
         status_in  = STATUS_ANTISTAR_TOO_FAR;
         den_fix_in = k3_den_ff;
      end
   end

   assign den_neg_in  = -den_fix_in;
   assign xnum_abs_in = k3_xnum_ff[PROD_W-1] ? -k3_xnum_ff : k3_xnum_ff;
   assign enum_abs_in = k3_enum_ff[PROD_W-1] ? -k3_enum_ff : k3_enum_ff;

   logic [NUM_W-1:0] k4_nx_ff, k4_ne_ff;
   logic [DEN_W-1:0] k4_ad_ff;
   div_info_type     k4_info_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         k1_sdst_ff <= k1_sdst_in;
         k1_sdct_ff <= k1_sdct_in;
         k1_cdct_ff <= k1_cdct_in;
         k1_cdst_ff <= k1_cdst_in;
         k1_xnum_ff <= k1_xnum_in;
         k1_cr_ff   <= cr;
         k2_m1_ff   <= k2_m1_in;
         k2_m2_ff   <= k2_m2_in;
         k2_sdst_ff <= k1_sdst_ff;
         k2_sdct_ff <= k1_sdct_ff;
         k2_xnum_ff <= k1_xnum_ff;
         k3_den_ff  <= (DEN_W+1)'(k3_sum_sh);
         k3_enum_ff <= k2_sdct_ff - k2_m2_ff;
         k3_xnum_ff <= k2_xnum_ff;
         k4_nx_ff   <= NUM_W'(xnum_abs_in);
         k4_ne_ff   <= NUM_W'(enum_abs_in);
         k4_ad_ff   <= den_fix_in[DEN_W] ? DEN_W'(den_neg_in) : DEN_W'(den_fix_in);
         k4_info_ff <= '{negx: k3_xnum_ff[PROD_W-1] ^ den_fix_in[DEN_W],
                         nege: k3_enum_ff[PROD_W-1] ^ den_fix_in[DEN_W],
                         satx: 1'b0, sate: 1'b0, status: status_in};
      end
   end

   // Divider set-up: scale to the output fraction and test for saturation.
   logic [DIV_W-1:0] dx_in, de_in, vtop_in;
   logic [VW-1:0]    v_in;
   div_info_type     info_in;

   assign dx_in   = DIV_W'(k4_nx_ff) << EXT_N;
   assign de_in   = DIV_W'(k4_ne_ff) << EXT_N;
   assign v_in    = VW'(k4_ad_ff) << EXT_D;
   assign vtop_in = DIV_W'(v_in) << QB;

   always_comb begin
      info_in      = k4_info_ff;
      info_in.satx = (dx_in >= vtop_in);
      info_in.sate = (de_in >= vtop_in);
   end

   // Restoring division, one quotient bit per stage for both numerators.
   logic [DIV_W-1:0] rx_ff [QB+1];
   logic [DIV_W-1:0] re_ff [QB+1];
   logic [QB-1:0]    qx_ff [QB+1];
   logic [QB-1:0]    qe_ff [QB+1];
   logic [VW-1:0]    vv_ff [QB+1];
   div_info_type     info_ff [QB+1];

   logic [DIV_W-1:0] shv [1:QB];
   logic [DIV_W-1:0] rx_in [1:QB];
   logic [DIV_W-1:0] re_in [1:QB];
   logic [QB-1:0]    qx_in [1:QB];
   logic [QB-1:0]    qe_in [1:QB];

   always_comb begin
      for (int s = 1; s <= QB; s++) begin
         shv[s] = DIV_W'(vv_ff[s-1]) << (QB - s);
         if (rx_ff[s-1] >= shv[s]) begin
            rx_in[s] = rx_ff[s-1] - shv[s];
            qx_in[s] = qx_ff[s-1] | (QB'(1) << (QB - s));
         end else begin
            rx_in[s] = rx_ff[s-1];
            qx_in[s] = qx_ff[s-1];
         end
         if (re_ff[s-1] >= shv[s]) begin
            re_in[s] = re_ff[s-1] - shv[s];
            qe_in[s] = qe_ff[s-1] | (QB'(1) << (QB - s));
         end else begin
            re_in[s] = re_ff[s-1];
            qe_in[s] = qe_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]   <= dx_in;
         re_ff[0]   <= de_in;
         qx_ff[0]   <= '0;
         qe_ff[0]   <= '0;
         vv_ff[0]   <= v_in;
         info_ff[0] <= info_in;
         for (int s = 1; s <= QB; s++) begin
            rx_ff[s]   <= rx_in[s];
            re_ff[s]   <= re_in[s];
            qx_ff[s]   <= qx_in[s];
            qe_ff[s]   <= qe_in[s];
            vv_ff[s]   <= vv_ff[s-1];
            info_ff[s] <= info_ff[s-1];
         end
      end
   end

   // Valid bits of every stage.
   logic [SC_LAT-1:0] vsc_ff;
   logic [3:0]        vk_ff;
   logic [QB:0]       dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         vsc_ff <= '0;
         vk_ff  <= '0;
         dv_ff  <= '0;
      end else if (en) begin
         v0_ff  <= req_valid;
         vsc_ff <= {vsc_ff[SC_LAT-2:0], v0_ff};
         vk_ff  <= {vk_ff[2:0], vsc_ff[SC_LAT-1]};
         dv_ff  <= {dv_ff[QB-1:0], vk_ff[3]};
      end
   end

   // Sign and saturation of the final quotients.
   logic [OUT_W-1:0] resx, rese, fin_xi, fin_eta;
   div_info_type     fin_info;

   assign fin_info = info_ff[QB];
   assign resx     = fin_info.satx ? OUT_MAX : {1'b0, qx_ff[QB]};
   assign rese     = fin_info.sate ? OUT_MAX : {1'b0, qe_ff[QB]};
   assign fin_xi   = fin_info.negx ? ('0 - resx) : resx;
   assign fin_eta  = fin_info.nege ? ('0 - rese) : rese;

   // Output register with one skid entry.
   logic             rsp_valid_ff, rsp_free, arrive;
   logic [OUT_W-1:0] rsp_xi_ff, rsp_eta_ff, skid_xi_ff, skid_eta_ff;
   status_type       rsp_status_ff, skid_status_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign arrive   = en && dv_ff[QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff  <= skid_valid_ff || arrive;
         skid_valid_ff <= 1'b0;
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_xi_ff     <= skid_xi_ff;
            rsp_eta_ff    <= skid_eta_ff;
            rsp_status_ff <= skid_status_ff;
         end else begin
            rsp_xi_ff     <= fin_xi;
            rsp_eta_ff    <= fin_eta;
            rsp_status_ff <= fin_info.status;
         end
      end else if (arrive) begin
         skid_xi_ff     <= fin_xi;
         skid_eta_ff    <= fin_eta;
         skid_status_ff <= fin_info.status;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_plane_xi          = $signed(rsp_xi_ff);
   assign rsp_plane_eta         = $signed(rsp_eta_ff);
   assign rsp_projection_status = rsp_status_ff;

endmodule
`default_nettype wire

// File: rtl/core/gtp_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gtp_sincos: pipelined sine and cosine of a binary angle
// Octant folding, then Horner evaluation of the Taylor series with one
// multiply per stage; results are signed Q30.
// ----------------------------------------------------------------------------
module gtp_sincos
   import gtp_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic [ANGLE_W-1:0]       angle,
   output logic signed [TRIG_W-1:0] sin_out,
   output logic signed [TRIG_W-1:0] cos_out
);

   typedef struct packed {
      logic [FRAC_W-1:0] x;
      logic [FRAC_W-1:0] x2;
      logic [1:0]        quad;
      logic              neg;
   } sc_carry_type;

   localparam int CAR_N = 3 * SC_STEPS + 1;
   localparam int PW    = 2 * FRAC_W + 1;
   localparam int QW    = 2 * FRAC_W;
   localparam logic [ANGLE_W-1:0] OCTANT_OFS = 32'h2000_0000;

   function automatic logic [FRAC_W:0] horner_t(input logic [FRAC_W-1:0] p,
                                                input logic [FRAC_W-1:0] qe,
                                                input logic [7:0]        dv);
      logic [FRAC_W+1:0] rem;
      logic [FRAC_W:0]   qf;
      rem = (FRAC_W+2)'(p) - (FRAC_W+2)'(qe) * (FRAC_W+2)'(dv);
      qf  = (rem >= (FRAC_W+2)'(dv)) ? (FRAC_W+1)'(qe) + 1'b1 : (FRAC_W+1)'(qe);
      return ONE_Q30 - qf;
   endfunction

   // Fold the angle into the octant around the nearest quadrant axis.
   logic [ANGLE_W-1:0] shifted_in, rem_in, neg_rem_in;
   logic [1:0]         quad_in;
   logic [FRAC_W-1:0]  mag_in;

   assign shifted_in = angle + OCTANT_OFS;
   assign quad_in    = shifted_in[ANGLE_W-1:ANGLE_W-2];
   assign rem_in     = angle - {quad_in, {(ANGLE_W-2){1'b0}}};
   assign neg_rem_in = '0 - rem_in;
   assign mag_in     = rem_in[ANGLE_W-1] ? neg_rem_in[FRAC_W-1:0] : rem_in[FRAC_W-1:0];

   logic [1:0]        quad_a_ff, quad_b_ff;
   logic              neg_a_ff, neg_b_ff;
   logic [FRAC_W-1:0] mag_a_ff, x_b_ff;
   logic [PW-1:0]     xprod_in;
   logic [QW-1:0]     x2prod_in;
   sc_carry_type      car_in;
   sc_carry_type      car_ff [CAR_N];

   assign xprod_in  = PW'(mag_a_ff) * PW'(HALF_PI_Q30);
   assign x2prod_in = QW'(x_b_ff) * QW'(x_b_ff);
   assign car_in    = '{x: x_b_ff, x2: x2prod_in[QW-1:FRAC_W], quad: quad_b_ff,
                        neg: neg_b_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         quad_a_ff <= quad_in;
         neg_a_ff  <= rem_in[ANGLE_W-1];
         mag_a_ff  <= mag_in;
         quad_b_ff <= quad_a_ff;
         neg_b_ff  <= neg_a_ff;
         x_b_ff    <= xprod_in[QW-1:FRAC_W];
         car_ff[0] <= car_in;
         for (int k = 1; k < CAR_N; k++) begin
            car_ff[k] <= car_ff[k-1];
         end
      end
   end

   logic [FRAC_W:0] ts_ff [SC_STEPS];
   logic [FRAC_W:0] tc_ff [SC_STEPS];

   for (genvar j = 0; j < SC_STEPS; j++) begin : g_step
      logic [FRAC_W:0]   tc_src;
      logic [PW-1:0]     pc_prod;
      logic [QW-1:0]     qc_prod;
      logic [FRAC_W-1:0] pc_ff, pcm_ff, qc_ff;

      if (j == 0) begin : g_first
         assign tc_src = ONE_Q30;
      end else begin : g_next
         assign tc_src = tc_ff[j-1];
      end

      assign pc_prod = PW'(car_ff[3*j].x2) * PW'(tc_src);
      assign qc_prod = QW'(pc_ff) * QW'(COS_RECIP[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            pc_ff    <= pc_prod[QW-1:FRAC_W];
            pcm_ff   <= pc_ff;
            qc_ff    <= qc_prod[QW-1:FRAC_W];
            tc_ff[j] <= horner_t(pcm_ff, qc_ff, COS_DIV[j]);
         end
      end

      // The sine series is one step shorter; its last step only carries t.
      if (j < SIN_TERMS) begin : g_sin
         logic [FRAC_W:0]   ts_src;
         logic [PW-1:0]     ps_prod;
         logic [QW-1:0]     qs_prod;
         logic [FRAC_W-1:0] ps_ff, psm_ff, qs_ff;

         if (j == 0) begin : g_first
            assign ts_src = ONE_Q30;
         end else begin : g_next
            assign ts_src = ts_ff[j-1];
         end

         assign ps_prod = PW'(car_ff[3*j].x2) * PW'(ts_src);
         assign qs_prod = QW'(ps_ff) * QW'(SIN_RECIP[j]);

         always_ff @(posedge clock) begin
            if (en) begin
               ps_ff    <= ps_prod[QW-1:FRAC_W];
               psm_ff   <= ps_ff;
               qs_ff    <= qs_prod[QW-1:FRAC_W];
               ts_ff[j] <= horner_t(psm_ff, qs_ff, SIN_DIV[j]);
            end
         end
      end else begin : g_sin_carry
         logic [FRAC_W:0] tsp_ff, tsm_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               tsp_ff   <= ts_ff[j-1];
               tsm_ff   <= tsp_ff;
               ts_ff[j] <= tsm_ff;
            end
         end
      end
   end

   logic [PW-1:0]            sprod_in;
   logic [FRAC_W:0]          smag_ff, cmag_ff;
   logic [1:0]               quad_f_ff;
   logic                     neg_f_ff;
   logic signed [TRIG_W-1:0] s_sg, c_sg, sin_ff, cos_ff;

   assign sprod_in = PW'(car_ff[CAR_N-1].x) * PW'(ts_ff[SC_STEPS-1]);
   assign s_sg = neg_f_ff ? -$signed(TRIG_W'(smag_ff)) : $signed(TRIG_W'(smag_ff));
   assign c_sg = $signed(TRIG_W'(cmag_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         smag_ff   <= sprod_in[PW-1:FRAC_W];
         cmag_ff   <= tc_ff[SC_STEPS-1];
         quad_f_ff <= car_ff[CAR_N-1].quad;
         neg_f_ff  <= car_ff[CAR_N-1].neg;
         case (quad_f_ff)
            2'd0: begin
               sin_ff <= s_sg;
               cos_ff <= c_sg;
            end
            2'd1: begin
               sin_ff <= c_sg;
               cos_ff <= -s_sg;
            end
            2'd2: begin
               sin_ff <= -s_sg;
               cos_ff <= -c_sg;
            end
            default: begin
               sin_ff <= -c_sg;
               cos_ff <= s_sg;
            end
         endcase
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire
